// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared constants for the quaternion vector rotator
// Fixed field widths, parameter defaults, pipeline depth and the width rule
// for the rotation-matrix entries.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Quaternion components are always 16-bit signed
  localparam int QUAT_W = 16;

  // Parameter defaults
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF      = 32;

  // Register stages from input to output register
  localparam int NUM_STAGES = 6;

  // Matrix entry width: covers 2*(a*b +/- c*d) and 1.0 at 2*frac bits
  function automatic int entry_w(input int frac);
    int base;
    base = (2 * QUAT_W > 2 * frac) ? 2 * QUAT_W : 2 * frac;
    return base + 3;
  endfunction

endpackage

// ===== rtl/qvr_matrix.sv =====
// ----------------------------------------------------------------------------
// qvr_matrix: quaternion to rotation matrix, two pipeline stages
// Stage 1 forms the nine quaternion component products, stage 2 forms the
// nine matrix entries, arranged as [output row][vector component].
// ----------------------------------------------------------------------------
module qvr_matrix #(
  parameter int  QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int  VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  localparam int EntW           = qvr_pkg::entry_w(QUAT_FRAC_BITS)
) (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_x_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_y_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_z_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_w_i,
  input  logic signed [VEC_WIDTH-1:0]       vec_i [3],
  output logic signed [EntW-1:0]            ent_o [3][3],
  output logic signed [VEC_WIDTH-1:0]       vec_o [3]
);
  import qvr_pkg::*;

  localparam int ProdW = 2 * QUAT_W;
  localparam logic signed [EntW-1:0] OneFx = EntW'(1) << (2 * QUAT_FRAC_BITS);

  // 2*(a + b) or 2*(a - b) at entry width
  function automatic logic signed [EntW-1:0] dbl(input logic signed [ProdW-1:0] a,
                                                   input logic signed [ProdW-1:0] b,
                                                   input logic sub);
    logic signed [EntW-1:0] s;
    s = sub ? (EntW'(a) - EntW'(b)) : (EntW'(a) + EntW'(b));
    return s <<< 1;
  endfunction

  logic signed [ProdW-1:0]     xx_q, yy_q, zz_q, xy_q, zw_q, zx_q, yw_q, yz_q, xw_q;
  logic signed [VEC_WIDTH-1:0] vec1_q [3];
  logic signed [EntW-1:0]      ent_d [3][3];
  logic signed [EntW-1:0]      ent_q [3][3];
  logic signed [VEC_WIDTH-1:0] vec2_q [3];

  // Stage 1: component products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xx_q   <= ProdW'(quat_x_i) * ProdW'(quat_x_i);
      yy_q   <= ProdW'(quat_y_i) * ProdW'(quat_y_i);
      zz_q   <= ProdW'(quat_z_i) * ProdW'(quat_z_i);
      xy_q   <= ProdW'(quat_x_i) * ProdW'(quat_y_i);
      zw_q   <= ProdW'(quat_z_i) * ProdW'(quat_w_i);
      zx_q   <= ProdW'(quat_z_i) * ProdW'(quat_x_i);
      yw_q   <= ProdW'(quat_y_i) * ProdW'(quat_w_i);
      yz_q   <= ProdW'(quat_y_i) * ProdW'(quat_z_i);
      xw_q   <= ProdW'(quat_x_i) * ProdW'(quat_w_i);
      vec1_q <= vec_i;
    end
  end

  // Matrix entries, column-major layout folded into output rows
  always_comb begin
    ent_d[0][0] = OneFx - dbl(yy_q, zz_q, 1'b0);  // e0
    ent_d[0][1] = dbl(xy_q, zw_q, 1'b0);          // e4
    ent_d[0][2] = dbl(zx_q, yw_q, 1'b1);          // e8
    ent_d[1][0] = dbl(xy_q, zw_q, 1'b1);          // e1
    ent_d[1][1] = OneFx - dbl(zz_q, xx_q, 1'b0);  // e5
    ent_d[1][2] = dbl(yz_q, xw_q, 1'b0);          // e9
    ent_d[2][0] = dbl(zx_q, yw_q, 1'b0);          // e2
    ent_d[2][1] = dbl(yz_q, xw_q, 1'b1);          // e6
    ent_d[2][2] = OneFx - dbl(yy_q, xx_q, 1'b0);  // e10
  end

  // Stage 2: entry register
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ent_q  <= ent_d;
      vec2_q <= vec1_q;
    end
  end

  assign ent_o = ent_q;
  assign vec_o = vec2_q;

endmodule

// ===== rtl/qvr_dot3.sv =====
// ----------------------------------------------------------------------------
// qvr_dot3: one matrix row times the vector, rounded and saturated
// Stage 3 split multiplies, stage 4 partial-product merge, stage 5 exact
// three-term sum with rounding offset, stage 6 shift and saturate.
// ----------------------------------------------------------------------------
module qvr_dot3 #(
  parameter int  QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int  VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  localparam int EntW           = qvr_pkg::entry_w(QUAT_FRAC_BITS)
) (
  input  logic                        clk_i,
  input  logic [3:0]                  en_i,
  input  logic signed [EntW-1:0]      ent_i [3],
  input  logic signed [VEC_WIDTH-1:0] vec_i [3],
  output logic signed [VEC_WIDTH-1:0] res_o
);
  import qvr_pkg::*;

  localparam int LoW   = VEC_WIDTH / 2;
  localparam int HiW   = VEC_WIDTH - LoW;
  localparam int PlW   = EntW + LoW + 1;
  localparam int PhW   = EntW + HiW;
  localparam int ProdW = EntW + VEC_WIDTH;
  localparam int SumW  = ProdW + 2;
  localparam int Shift = 2 * QUAT_FRAC_BITS;

  localparam logic signed [SumW-1:0] Half   = SumW'(1) << (Shift - 1);
  localparam logic signed [SumW-1:0] SatMax = {{(SumW-VEC_WIDTH+1){1'b0}},
                                               {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = {{(SumW-VEC_WIDTH+1){1'b1}},
                                               {(VEC_WIDTH-1){1'b0}}};

  logic signed [PlW-1:0]       pl_q [3];
  logic signed [PhW-1:0]       ph_q [3];
  logic signed [ProdW-1:0]     prod_q [3];
  logic signed [SumW-1:0]      sum_q;
  logic signed [SumW-1:0]      rnd;
  logic signed [VEC_WIDTH-1:0] res_d;
  logic signed [VEC_WIDTH-1:0] res_q;

  // Stage 3: entry times low (unsigned) and high (signed) vector halves
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int c = 0; c < 3; c++) begin
        pl_q[c] <= PlW'(ent_i[c]) * PlW'($signed({1'b0, vec_i[c][LoW-1:0]}));
        ph_q[c] <= PhW'(ent_i[c]) * PhW'($signed(vec_i[c][VEC_WIDTH-1:LoW]));
      end
    end
  end

  // Stage 4: merge halves into exact products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= (ProdW'(ph_q[c]) <<< LoW) + ProdW'(pl_q[c]);
      end
    end
  end

  // Stage 5: exact sum plus half an output LSB
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q <= SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + Half;
    end
  end

  // Drop fraction bits and clamp to the vector range
  always_comb begin
    rnd = sum_q >>> Shift;
    if (rnd > SatMax) begin
      res_d = SatMax[VEC_WIDTH-1:0];
    end else if (rnd < SatMin) begin
      res_d = SatMin[VEC_WIDTH-1:0];
    end else begin
      res_d = rnd[VEC_WIDTH-1:0];
    end
  end

  // Stage 6: output register
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/quaternion_vector_rotator.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotator: rotate a vector by a quaternion
// Usage:
//   Slave stream carries one request per beat: a quaternion (x, y, z, w),
//   signed with QUAT_FRAC_BITS fraction bits, and a vector (x, y, z) of
//   VEC_WIDTH-bit signed values. The master stream returns the rotated
//   vector, rounded half up and saturated to VEC_WIDTH bits.
//   A request passes through six register stages: products, matrix
//   entries, split multiplies, product merge, three-term sum, round and
//   saturate into the output register. Throughput is one request per
//   cycle while the receiver takes results.
//   Reset clears every stage valid bit; payload registers are not reset.
//   When the receiver stalls, the output register holds its result and
//   the stages behind it keep filling; s_axis_tready drops only once every
//   stage holds a request. Empty stages are squeezed out, so nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotator #(
  parameter int  QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int  VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  localparam int InW            = 4 * qvr_pkg::QUAT_W + 3 * VEC_WIDTH,
  localparam int InDataW        = ((InW + 7) / 8) * 8,
  localparam int OutDataW       = ((3 * VEC_WIDTH + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, vec_in_x, vec_in_y, vec_in_z, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vec_out_x, vec_out_y, vec_out_z, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);
  import qvr_pkg::*;

  localparam int EntW = entry_w(QUAT_FRAC_BITS);
  localparam int CntW = $clog2(NUM_STAGES + 1);

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic signed [QUAT_W-1:0]    quat_x, quat_y, quat_z, quat_w;
  logic signed [VEC_WIDTH-1:0] vec_in [3];
  logic signed [EntW-1:0]      ent [3][3];
  logic signed [VEC_WIDTH-1:0] vec_s2 [3];
  logic signed [VEC_WIDTH-1:0] vec_out [3];
  logic [CntW-1:0]             inflight_q;

  // Unpack the request
  assign quat_x = s_axis_tdata[0*QUAT_W +: QUAT_W];
  assign quat_y = s_axis_tdata[1*QUAT_W +: QUAT_W];
  assign quat_z = s_axis_tdata[2*QUAT_W +: QUAT_W];
  assign quat_w = s_axis_tdata[3*QUAT_W +: QUAT_W];
  assign vec_in[0] = s_axis_tdata[4*QUAT_W + 0*VEC_WIDTH +: VEC_WIDTH];
  assign vec_in[1] = s_axis_tdata[4*QUAT_W + 1*VEC_WIDTH +: VEC_WIDTH];
  assign vec_in[2] = s_axis_tdata[4*QUAT_W + 2*VEC_WIDTH +: VEC_WIDTH];

  // Stage enables: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stages 1-2: matrix entries
  qvr_matrix #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
    .VEC_WIDTH     (VEC_WIDTH)
  ) u_matrix (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .quat_x_i(quat_x),
    .quat_y_i(quat_y),
    .quat_z_i(quat_z),
    .quat_w_i(quat_w),
    .vec_i   (vec_in),
    .ent_o   (ent),
    .vec_o   (vec_s2)
  );

  // Stages 3-6: one dot product per output component
  for (genvar r = 0; r < 3; r++) begin : g_row
    qvr_dot3 #(
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS),
      .VEC_WIDTH     (VEC_WIDTH)
    ) u_dot3 (
      .clk_i(clk_i),
      .en_i (en[5:2]),
      .ent_i(ent[r]),
      .vec_i(vec_s2),
      .res_o(vec_out[r])
    );
  end

  // Pack the result
  assign m_axis_tvalid = v_q[NUM_STAGES-1];

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0*VEC_WIDTH +: VEC_WIDTH] = vec_out[0];
    m_axis_tdata[1*VEC_WIDTH +: VEC_WIDTH] = vec_out[1];
    m_axis_tdata[2*VEC_WIDTH +: VEC_WIDTH] = vec_out[2];
  end

  // Requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(s_axis_tvalid && s_axis_tready)
                               - CntW'(m_axis_tvalid && m_axis_tready);
    end
  end

  // Every outstanding request sits in exactly one stage
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == CntW'($countones(v_q)))
    else $error("in-flight count does not match stage valid bits");

  // Input is only held off when the pipe is full and the output is stalled
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ((&v_q) && !m_axis_tready))
    else $error("input stalled while a stage is empty");

  // A full pipe with a stalled receiver must block the input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the pipe cannot advance");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stream testbench for quaternion_vector_rotator
// Requests carrying a quaternion and a vector are sent from a queue with
// random gaps, and results are taken with random stalls. Every accepted
// request is rotated by an exact wide-integer model here, and each result
// is checked field by field, in order, against the oldest expected vector.
// ----------------------------------------------------------------------------
module tb;

  import qvr_pkg::*;

  localparam int FRAC   = QUAT_FRAC_BITS_DEF;
  localparam int VW     = VEC_WIDTH_DEF;
  localparam int IN_DW  = ((4 * QUAT_W + 3 * VW + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * VW + 7) / 8) * 8;
  localparam int ONE_Q  = 1 << FRAC;
  localparam int N_RAND = 1330;

  localparam logic signed [VW-1:0]  VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0]  VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [127:0]   HALF = 128'sd1 <<< (2 * FRAC - 1);
  localparam logic signed [127:0]   WMAX = VMAX;
  localparam logic signed [127:0]   WMIN = VMIN;

  typedef struct {
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [VW-1:0]     vec_in_x;
    logic signed [VW-1:0]     vec_in_y;
    logic signed [VW-1:0]     vec_in_z;
  } rot_req_t;

  typedef struct {
    logic [VW-1:0] vec_out_x;
    logic [VW-1:0] vec_out_y;
    logic [VW-1:0] vec_out_z;
  } rot_vec_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // quat_x, quat_y, quat_z, quat_w, vec_in_x, vec_in_y, vec_in_z
  logic [IN_DW-1:0]  s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // vec_out_x, vec_out_y, vec_out_z
  logic [OUT_DW-1:0] m_axis_tdata;

  rot_req_t request_q[$];
  rot_vec_t rotated_q[$];
  rot_req_t cur_req;
  int       err_cnt   = 0;
  int       src_wait  = 0;
  int       src_calm  = 0;
  int       sink_wait = 0;
  int       sink_calm = 0;

  quaternion_vector_rotator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Round half up at 2*FRAC fraction bits, then clamp to the vector width
  function automatic logic [VW-1:0] round_sat(input logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + HALF) >>> (2 * FRAC);
    if (r > WMAX) return VMAX;
    if (r < WMIN) return VMIN;
    return r[VW-1:0];
  endfunction

  // Build the rotation matrix exactly and multiply the original vector
  function automatic rot_vec_t rotate_vector(input rot_req_t r);
    logic signed [127:0] qx, qy, qz, qw, vx, vy, vz, one_v;
    logic signed [127:0] e0, e1, e2, e4, e5, e6, e8, e9, e10;
    rot_vec_t o;
    qx = r.quat_x;   qy = r.quat_y;   qz = r.quat_z;   qw = r.quat_w;
    vx = r.vec_in_x; vy = r.vec_in_y; vz = r.vec_in_z;
    one_v = 128'sd1 <<< (2 * FRAC);
    e0  = one_v - 2 * (qy * qy + qz * qz);
    e1  = 2 * (qx * qy - qz * qw);
    e2  = 2 * (qz * qx + qy * qw);
    e4  = 2 * (qx * qy + qz * qw);
    e5  = one_v - 2 * (qz * qz + qx * qx);
    e6  = 2 * (qy * qz - qx * qw);
    e8  = 2 * (qz * qx - qy * qw);
    e9  = 2 * (qy * qz + qx * qw);
    e10 = one_v - 2 * (qy * qy + qx * qx);
    o.vec_out_x = round_sat(e0 * vx + e4 * vy + e8 * vz);
    o.vec_out_y = round_sat(e1 * vx + e5 * vy + e9 * vz);
    o.vec_out_z = round_sat(e2 * vx + e6 * vy + e10 * vz);
    return o;
  endfunction

  function automatic rot_req_t make_req(
    input logic signed [QUAT_W-1:0] qx, qy, qz, qw,
    input logic signed [VW-1:0]     vx, vy, vz
  );
    rot_req_t r;
    r.quat_x = qx;   r.quat_y = qy;   r.quat_z = qz;   r.quat_w = qw;
    r.vec_in_x = vx; r.vec_in_y = vy; r.vec_in_z = vz;
    return r;
  endfunction

  // Quaternion part: anywhere in range, or one of the edge values
  function automatic logic signed [QUAT_W-1:0] rand_quat_part(input bit edgy);
    if (!edgy) return QUAT_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
    case ($urandom_range(0, 4))
      0:       return -ONE_Q;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return ONE_Q;
    endcase
  endfunction

  // Vector part: mostly moderate values, some full range and extremes
  function automatic logic signed [VW-1:0] rand_vec_part();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // Gap or stall length, with calm stretches of no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 11);
  endfunction

  // Driver: present queued requests, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    rot_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) rotated_q.push_back(rotate_vector(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0 || request_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (src_wait > 0) src_wait <= src_wait - 1;
        end else begin
          nxt = request_q.pop_front();
          cur_req       <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.vec_in_z, nxt.vec_in_y, nxt.vec_in_x,
                            nxt.quat_w, nxt.quat_z, nxt.quat_y, nxt.quat_x};
          src_wait      <= draw_wait(src_calm);
        end
      end
    end
  end

  // Monitor: stall at random after each result, compare against the oldest
  always @(posedge clk_i or negedge rst_ni) begin
    rot_vec_t exp_v, got;
    int w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got.vec_out_x = m_axis_tdata[VW-1:0];
      got.vec_out_y = m_axis_tdata[2*VW-1:VW];
      got.vec_out_z = m_axis_tdata[3*VW-1:2*VW];
      if (rotated_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected: x=%h y=%h z=%h", $time,
                 got.vec_out_x, got.vec_out_y, got.vec_out_z);
      end else begin
        exp_v = rotated_q.pop_front();
        if (got.vec_out_x !== exp_v.vec_out_x) begin
          err_cnt++;
          $display("%0t: vec_out_x expected %h actual %h", $time,
                   exp_v.vec_out_x, got.vec_out_x);
        end
        if (got.vec_out_y !== exp_v.vec_out_y) begin
          err_cnt++;
          $display("%0t: vec_out_y expected %h actual %h", $time,
                   exp_v.vec_out_y, got.vec_out_y);
        end
        if (got.vec_out_z !== exp_v.vec_out_z) begin
          err_cnt++;
          $display("%0t: vec_out_z expected %h actual %h", $time,
                   exp_v.vec_out_z, got.vec_out_z);
        end
      end
      w = draw_wait(sink_calm);
      sink_wait     <= w;
      m_axis_tready <= (w == 0);
    end else if (sink_wait > 0) begin
      sink_wait     <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    real a, b, c, d, n;
    int  kind;
    logic signed [QUAT_W-1:0] h;
    h = 11585;  // cos(45 deg) in Q1.14

    // Identity, zero quaternion and half turns about each axis
    request_q.push_back(make_req(0, 0, 0, ONE_Q, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000));
    request_q.push_back(make_req(0, 0, 0, 0, 32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0001));
    request_q.push_back(make_req(ONE_Q, 0, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    request_q.push_back(make_req(0, ONE_Q, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    request_q.push_back(make_req(0, 0, ONE_Q, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    request_q.push_back(make_req(0, 0, 0, -ONE_Q, -32'sh0001_0000, 32'sh0000_8000, 32'sh7fff_0000));
    // Quarter turns about x, y and z
    request_q.push_back(make_req(h, 0, 0, h, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    request_q.push_back(make_req(0, h, 0, h, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    request_q.push_back(make_req(0, 0, -h, h, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    // Exact halves on y and z, both signs: ties go toward plus infinity
    request_q.push_back(make_req(ONE_Q / 2, 0, 0, 0, 0, 1, -1));
    request_q.push_back(make_req(ONE_Q / 2, 0, 0, 0, 0, -1, 1));
    request_q.push_back(make_req(ONE_Q / 2, 0, 0, 0, 0, 3, -3));
    request_q.push_back(make_req(ONE_Q / 2, 0, 0, 0, 5, -5, 7));
    // Non-unit quaternions, some driving the sums into both clamps
    request_q.push_back(make_req(ONE_Q, ONE_Q, ONE_Q, ONE_Q, VMAX, VMAX, VMAX));
    request_q.push_back(make_req(ONE_Q, ONE_Q, ONE_Q, ONE_Q, VMIN, VMIN, VMIN));
    request_q.push_back(make_req(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, VMAX, VMIN, VMAX));
    request_q.push_back(make_req(-ONE_Q, ONE_Q, -ONE_Q, ONE_Q, VMIN, VMAX, VMIN));
    request_q.push_back(make_req(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, 0, 0, 0));
    request_q.push_back(make_req(-1, -1, -1, -1, -1, -1, -1));
    // Vector extremes through the identity
    request_q.push_back(make_req(0, 0, 0, ONE_Q, VMAX, VMIN, 0));
    request_q.push_back(make_req(0, 0, 0, ONE_Q, -1, 1, VMIN));

    // Random part: unit quaternions, arbitrary ones and edge values
    for (int i = 0; i < N_RAND; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) begin
          d = 1.0;
          n = 1.0;
        end
        request_q.push_back(make_req(QUAT_W'($rtoi(a / n * ONE_Q)),
                                     QUAT_W'($rtoi(b / n * ONE_Q)),
                                     QUAT_W'($rtoi(c / n * ONE_Q)),
                                     QUAT_W'($rtoi(d / n * ONE_Q)),
                                     rand_vec_part(), rand_vec_part(), rand_vec_part()));
      end else begin
        request_q.push_back(make_req(rand_quat_part(kind >= 8), rand_quat_part(kind >= 8),
                                     rand_quat_part(kind >= 8), rand_quat_part(kind >= 8),
                                     rand_vec_part(), rand_vec_part(), rand_vec_part()));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (request_q.size() == 0 && !s_axis_tvalid);
    wait (rotated_q.size() == 0);
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (err_cnt == 0 && rotated_q.size() == 0) begin
      $display("PASS quaternion_vector_rotator");
    end else begin
      $display("FAIL quaternion_vector_rotator");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAIL quaternion_vector_rotator");
    $finish;
  end

endmodule
